>>> hw/rtl/smx_pkg.sv
// Package for the stack machine executor: codes, types and decode function.
package smx_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [3:0] {
    OP_END     = 4'd0,
    OP_ADD     = 4'd1,
    OP_SUB     = 4'd2,
    OP_MUL     = 4'd3,
    OP_DIV     = 4'd4,
    OP_SWAP    = 4'd5,
    OP_PRINT   = 4'd6,
    OP_DUP     = 4'd7,
    OP_DROP    = 4'd8,
    OP_NIP     = 4'd9,
    OP_ROT     = 4'd10,
    OP_PUSH    = 4'd11,
    OP_INVALID = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_INVALID = 3'd2,
    ST_OVER    = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_HALTED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_CAPT,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_DONE
  } back_state_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    op_t         op;
    logic [1:0]  nreads;
    logic [31:0] imm;
  } item_t;

  function automatic item_t decode(input logic [3:0] kind, input logic [31:0] imm);
    item_t it;
    it.imm = imm;
    it.nreads = 2'd0;
    // Every kind above push is invalid.
    if (kind > OP_PUSH) begin
      it.op = OP_INVALID;
    end else begin
      it.op = op_t'(kind);
    end
    case (it.op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_NIP: it.nreads = 2'd2;
      OP_ROT: it.nreads = 2'd3;
      OP_PRINT, OP_DUP, OP_DROP: it.nreads = 2'd1;
      default: it.nreads = 2'd0;
    endcase
    return it;
  endfunction

endpackage

>>> hw/rtl/stack_machine_executor.sv
// Top level of the stack machine executor: front end, queue and back end.
// Each input request carries one decoded instruction (kind) and an immediate
// that only push uses. Every request yields exactly one result request on the
// output channel with a status, a flag telling whether print popped a value,
// and that value. Both channels move a request when valid is high and stall is
// low at a rising edge.
// The front end classifies the instruction and places it in a two-entry
// queue, so it keeps taking requests while the back end works or while a
// result waits in the output register for the receiver.
// The back end works on one instruction at a time against a stack memory with
// one write port and a registered read port: it reads each operand with an
// issue and a capture step, executes, then writes each result word; division
// runs in the one-bit-a-cycle divider. Halted and end requests, and those
// failing the kind or depth checks, go straight to the result state.
// Reset clears the stack depth and the halt flag and empties the queue and the
// output register; the stack memory itself is not cleared, as only entries
// that have been written are ever read.
// When the receiver stalls, the result holds in the output register, the back
// end waits with its next result, and the queue fills until the input stalls.
// Once an error or end has been seen, every later request answers halted.
module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  kind,
  input  logic [31:0] immediate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic        has_value,
  output logic [31:0] printed_value
);
  import smx_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  smx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .immediate (immediate),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  smx_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .has_value     (has_value),
    .printed_value (printed_value)
  );

endmodule

>>> hw/rtl/smx_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module smx_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [3:0]    kind,
  input  logic [31:0]   immediate,
  output logic          q_valid,
  output smx_pkg::item_t q_item,
  input  logic          q_pop
);
  import smx_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t          buffer [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign in_stall = (count == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_item   = buffer[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buffer[wr_ptr] <= decode(kind, immediate);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/smx_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import smx_pkg::*;

  localparam int unsigned NW = $clog2(DIV_STEPS + 1);

  logic          running;
  logic [NW-1:0] cnt;
  logic [31:0]   rem;
  logic [31:0]   quo;
  logic [31:0]   dvs;
  logic          neg;
  logic [32:0]   trial;
  logic [32:0]   diff;

  assign trial    = {rem, quo[31]};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg <= dividend[31] ^ divisor[31];
    end else if (running) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= running && !start && (cnt == NW'(1));
      if (start) begin
        running <= 1'b1;
        cnt     <= NW'(DIV_STEPS);
      end else if (running) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

endmodule

>>> hw/rtl/smx_back.sv
// Back end: checks each request against the stack, runs it on the stack memory, returns the result.
module smx_back #(
  parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  smx_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     status,
  output logic           has_value,
  output logic [31:0]    printed_value
);
  import smx_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic [31:0]   mem [STACK_DEPTH];
  logic [31:0]   mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;

  back_state_t   state;
  back_state_t   state_next;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_pend;
  logic          halted;
  item_t         cur;
  logic [1:0]    rcnt;
  logic [31:0]   op [3];
  logic [1:0]    wtotal;
  logic [1:0]    widx;
  logic [AW-1:0] waddr [3];
  logic [31:0]   wdata [3];
  status_t       res_status;
  logic [31:0]   res_pv;
  logic          res_hv;

  status_t       fetch_status;
  logic          fetch_halt;
  logic [DW-1:0] dm1;
  logic [DW-1:0] dm2;
  logic [DW-1:0] dm3;
  logic          out_free;
  logic          div_start;
  logic          div_done;
  logic [31:0]   div_q;

  assign dm1      = depth - DW'(1);
  assign dm2      = depth - DW'(2);
  assign dm3      = depth - DW'(3);
  assign out_free = !out_valid || !out_stall;

  // Checks that need only the halt flag, the opcode and the stack depth, in the order of priority.
  always_comb begin
    fetch_status = ST_OK;
    fetch_halt   = 1'b0;
    if (halted) begin
      fetch_status = ST_HALTED;
    end else if (q_item.op == OP_END) begin
      fetch_halt = 1'b1;
    end else if (q_item.op == OP_INVALID) begin
      fetch_status = ST_INVALID;
      fetch_halt   = 1'b1;
    end else if (depth < DW'(q_item.nreads)) begin
      fetch_status = ST_UNDER;
      fetch_halt   = 1'b1;
    end else if ((q_item.op == OP_PUSH || q_item.op == OP_DUP) &&
                 depth >= DW'(STACK_DEPTH)) begin
      fetch_status = ST_OVER;
      fetch_halt   = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (halted || fetch_status != ST_OK || q_item.op == OP_END) begin
            state_next = S_DONE;
          end else if (q_item.nreads == 2'd0) begin
            state_next = S_EXEC;
          end else begin
            state_next = S_ISSUE;
          end
        end
      end
      S_ISSUE: state_next = S_CAPT;
      S_CAPT: begin
        state_next = (rcnt + 2'd1 == cur.nreads) ? S_EXEC : S_ISSUE;
      end
      S_EXEC: begin
        if (cur.op == OP_DIV) begin
          state_next = (op[0] == 32'd0) ? S_DONE : S_DIV;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (widx == wtotal) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == S_IDLE) && q_valid;
    mem_we    = (state == S_WRITE) && (widx != wtotal);
    mem_waddr = waddr[widx];
    div_start = (state == S_EXEC) && (cur.op == OP_DIV) && (op[0] != 32'd0);
    case (rcnt)
      2'd0:    mem_raddr = dm1[AW-1:0];
      2'd1:    mem_raddr = dm2[AW-1:0];
      default: mem_raddr = dm3[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= wdata[widx];
    end
    mem_q <= mem[mem_raddr];
  end

  smx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (op[1]),
    .divisor  (op[0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur        <= q_item;
        res_status <= fetch_status;
        res_hv     <= 1'b0;
        res_pv     <= '0;
        rcnt       <= '0;
        widx       <= '0;
        wtotal     <= '0;
        depth_pend <= depth;
      end
      S_CAPT: begin
        op[rcnt] <= mem_q;
        rcnt     <= rcnt + 2'd1;
      end
      S_EXEC: begin
        case (cur.op)
          OP_ADD: begin
            waddr[0] <= dm2[AW-1:0]; wdata[0] <= op[1] + op[0];
            wtotal <= 2'd1; depth_pend <= dm1;
          end
          OP_SUB: begin
            waddr[0] <= dm2[AW-1:0]; wdata[0] <= op[1] - op[0];
            wtotal <= 2'd1; depth_pend <= dm1;
          end
          OP_MUL: begin
            waddr[0] <= dm2[AW-1:0]; wdata[0] <= op[1] * op[0];
            wtotal <= 2'd1; depth_pend <= dm1;
          end
          OP_DIV: begin
            waddr[0] <= dm2[AW-1:0];
            wtotal <= 2'd1; depth_pend <= dm1;
            if (op[0] == 32'd0) begin
              res_status <= ST_DIVZERO;
            end
          end
          OP_SWAP: begin
            waddr[0] <= dm1[AW-1:0]; wdata[0] <= op[1];
            waddr[1] <= dm2[AW-1:0]; wdata[1] <= op[0];
            wtotal <= 2'd2;
          end
          OP_PRINT: begin
            res_hv <= 1'b1; res_pv <= op[0]; depth_pend <= dm1;
          end
          OP_DUP: begin
            waddr[0] <= depth[AW-1:0]; wdata[0] <= op[0];
            wtotal <= 2'd1; depth_pend <= depth + DW'(1);
          end
          OP_DROP: depth_pend <= dm1;
          OP_NIP: begin
            waddr[0] <= dm2[AW-1:0]; wdata[0] <= op[0];
            wtotal <= 2'd1; depth_pend <= dm1;
          end
          OP_ROT: begin
            waddr[0] <= dm3[AW-1:0]; wdata[0] <= op[1];
            waddr[1] <= dm2[AW-1:0]; wdata[1] <= op[0];
            waddr[2] <= dm1[AW-1:0]; wdata[2] <= op[2];
            wtotal <= 2'd3;
          end
          OP_PUSH: begin
            waddr[0] <= depth[AW-1:0]; wdata[0] <= cur.imm;
            wtotal <= 2'd1; depth_pend <= depth + DW'(1);
          end
          default: wtotal <= '0;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          wdata[0] <= div_q;
        end
      end
      S_WRITE: begin
        if (widx != wtotal) begin
          widx <= widx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && q_valid && fetch_halt) begin
        halted <= 1'b1;
      end
      if (state == S_EXEC && cur.op == OP_DIV && op[0] == 32'd0) begin
        halted <= 1'b1;
      end
      if (state == S_WRITE && widx == wtotal) begin
        depth <= depth_pend;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status        <= res_status;
      has_value     <= res_hv;
      printed_value <= res_pv;
    end
  end

endmodule

>>> hw/rtl/smx_checker.sv
// Port-level checker for the stack machine executor, with its bind.
module smx_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic        has_value,
  input logic [31:0] printed_value
);
  import smx_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(printed_value))
    else $error("stalled result changed");

  a_value_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_value |-> status == ST_OK)
    else $error("printed value with error status");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_value |-> printed_value == 32'd0)
    else $error("nonzero value without print");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_HALTED)
    else $error("status code out of range");

endmodule

bind stack_machine_executor smx_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .has_value     (has_value),
  .printed_value (printed_value)
);

>>> dv/stack_machine_executor_tb.sv
// Testbench for the stack machine executor: drives instructions, predicts and checks results.
`timescale 1ns / 100ps

module stack_machine_executor_tb;
  import smx_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

  // One expected result request.
  typedef struct {
    status_t     st;
    logic        hv;
    logic [31:0] pv;
  } outcome_t;

  // Keeps a shadow of the machine, works out what each accepted instruction
  // should answer and compares the answers as they come out, oldest first.
  class exec_scoreboard;
    logic [31:0] stk [DEPTH];
    int unsigned depth;
    bit          halted;
    outcome_t    awaited[$];
    int unsigned errors;

    function new();
      depth = 0;
      halted = 0;
      errors = 0;
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // Signed quotient truncated toward zero; the most negative value over
    // minus one wraps back to itself.
    function logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
      if (b == 32'hffff_ffff) return 32'd0 - a;
      return $signed(a) / $signed(b);
    endfunction

    function int unsigned operands(input op_t op);
      case (op)
        OP_ROT: return 3;
        OP_PRINT, OP_DUP, OP_DROP: return 1;
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP, OP_NIP: return 2;
        default: return 0;
      endcase
    endfunction

    function void note(input logic [3:0] kind, input logic [31:0] imm);
      outcome_t    o;
      op_t         op;
      int unsigned t;
      int unsigned s;
      logic [31:0] x;
      o.st = ST_OK;
      o.hv = 0;
      o.pv = '0;
      op = (kind > 4'd11) ? OP_INVALID : op_t'(kind);
      if (halted) begin
        o.st = ST_HALTED;
      end else if (op == OP_END) begin
        halted = 1;
      end else if (op == OP_INVALID) begin
        o.st = ST_INVALID;
      end else if (op == OP_PUSH) begin
        if (depth >= DEPTH) begin
          o.st = ST_OVER;
        end else begin
          stk[depth] = imm;
          depth++;
        end
      end else if (depth < operands(op)) begin
        o.st = ST_UNDER;
      end else begin
        t = depth - 1;
        s = (t >= 1) ? t - 1 : 0;
        case (op)
          OP_ADD: begin stk[s] = stk[s] + stk[t]; depth--; end
          OP_SUB: begin stk[s] = stk[s] - stk[t]; depth--; end
          OP_MUL: begin stk[s] = stk[s] * stk[t]; depth--; end
          OP_DIV: begin
            if (stk[t] == 0) begin
              o.st = ST_DIVZERO;
            end else begin
              stk[s] = quotient(stk[s], stk[t]);
              depth--;
            end
          end
          OP_SWAP: begin x = stk[t]; stk[t] = stk[s]; stk[s] = x; end
          OP_PRINT: begin o.pv = stk[t]; o.hv = 1; depth--; end
          OP_DUP: begin
            if (depth >= DEPTH) begin
              o.st = ST_OVER;
            end else begin
              stk[depth] = stk[t];
              depth++;
            end
          end
          OP_DROP: depth--;
          OP_NIP: begin stk[s] = stk[t]; depth--; end
          default: begin
            x = stk[t - 2];
            stk[t - 2] = stk[s];
            stk[s] = stk[t];
            stk[t] = x;
          end
        endcase
      end
      if (o.st != ST_OK && o.st != ST_HALTED) halted = 1;
      awaited.push_back(o);
    endfunction

    task check(input logic [2:0] st, input logic hv, input logic [31:0] pv);
      outcome_t o;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result status=%0d", st));
      end else begin
        o = awaited.pop_front();
        if (st !== o.st)
          report($sformatf("status %0d, expected %0d", st, o.st));
        if (hv !== o.hv)
          report($sformatf("has_value %0b, expected %0b", hv, o.hv));
        if (pv !== o.pv)
          report($sformatf("printed_value %h, expected %h", pv, o.pv));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  kind = '0;
  logic [31:0] immediate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic        has_value;
  logic [31:0] printed_value;

  exec_scoreboard sb = new();
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    cycles = 0;

  stack_machine_executor u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .immediate(immediate),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .has_value(has_value), .printed_value(printed_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL stack_machine_executor");
      $finish;
    end
  end

  // Receiver: stalls at random according to the current phase and checks
  // each result request on the edge that accepts it. Values read here are
  // those from just before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check(status, has_value, printed_value);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sends one instruction, inserting random idle cycles first, and notes it
  // in the scoreboard on the edge at which it is accepted. The valid line is
  // left high, so back-to-back requests keep it high without a gap.
  task send(input logic [3:0] k, input logic [31:0] imm);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    immediate <= imm;
    do @(posedge clk); while (in_stall);
    sb.note(k, imm);
  endtask

  task send_op(input op_t op, input logic [31:0] imm);
    send(4'(op), imm);
  endtask

  // Immediate values: extremes, small numbers, single bits and full random.
  function logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return 32'($signed($urandom_range(16)) - 8);
      3: return 32'd1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  // A random instruction that the current shadow stack can execute without
  // error, so the machine keeps running. The stack mostly stays shallow.
  task send_legal();
    op_t         op;
    int unsigned d;
    bit          ok;
    d = sb.depth;
    ok = 0;
    while (!ok) begin
      if (d < 3 && $urandom_range(1)) op = OP_PUSH;
      else op = op_t'($urandom_range(11, 1));
      ok = (d >= sb.operands(op));
      if ((op == OP_PUSH || op == OP_DUP) && d >= 48) ok = 0;
      if (op == OP_DIV && ok && sb.stk[d - 1] == 0) ok = 0;
    end
    send_op(op, (op == OP_PUSH) ? pick_value() : $urandom());
  endtask

  task wait_drained();
    while (sb.awaited.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation but end, the immediate extremes, rot ordering and
    // the most negative value divided by minus one.
    send_op(OP_PUSH, MOST_NEG);
    send_op(OP_PUSH, 32'hffff_ffff);
    send_op(OP_DIV, '1);
    send_op(OP_PUSH, MOST_POS);
    send_op(OP_PUSH, 32'd0);
    send_op(OP_ROT, 32'h5a5a_5a5a);
    send_op(OP_PRINT, '0);
    send_op(OP_PUSH, 32'hffff_fff9);
    send_op(OP_PUSH, 32'd2);
    send_op(OP_DIV, '0);
    send_op(OP_DUP, '0);
    send_op(OP_ADD, '0);
    send_op(OP_PUSH, MOST_POS);
    send_op(OP_MUL, '0);
    send_op(OP_SWAP, '0);
    send_op(OP_SUB, '0);
    send_op(OP_PUSH, 32'd7);
    send_op(OP_NIP, '0);
    send_op(OP_PUSH, 32'd3);
    send_op(OP_DROP, '0);
    send_op(OP_PRINT, '0);
    send_op(OP_PRINT, '0);

    // Random phases: no idling, idle sender, stalling receiver, both light.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (n = 0; n < 160; n++) begin
        send_legal();
        // Once, hold the sender back until the machine has fully drained.
        if (phase == 2 && n == 80) wait_drained();
      end
    end

    // The run can only ever stop the machine once, so one terminating case
    // is chosen at random, followed by requests that must answer halted.
    pick = $urandom_range(4);
    case (pick)
      0: send_op(OP_END, $urandom());
      1: begin
        while (sb.depth > 0) send_op(OP_PRINT, '0);
        send(4'($urandom_range(5, 1)), $urandom());
      end
      2: send(4'($urandom_range(15, 12)), $urandom());
      3: begin
        if (sb.depth == 0) send_op(OP_PUSH, pick_value());
        while (sb.depth < DEPTH) begin
          if ($urandom_range(1)) send_op(OP_DUP, '0);
          else send_op(OP_PUSH, pick_value());
        end
        if ($urandom_range(1)) send_op(OP_DUP, '0);
        else send_op(OP_PUSH, pick_value());
      end
      default: begin
        send_op(OP_PUSH, pick_value());
        send_op(OP_PUSH, '0);
        send_op(OP_DIV, '0);
      end
    endcase
    for (n = 0; n < 6; n++) send(4'($urandom_range(15)), $urandom());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASS stack_machine_executor");
    end else begin
      $display("FAIL stack_machine_executor");
    end
    $finish;
  end

endmodule
